[hdl/cnv_pkg.sv]
// ----------------------------------------------------------------------------
// cnv_pkg: shared types and constants
// Register indexes, request codes, field widths and the control and result
// records that travel down the convolution pipeline.
// ----------------------------------------------------------------------------
package cnv_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 48;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 10;
	localparam int IN_LANES   = 3;
	localparam int MAX_HEIGHT = 4096;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic REQ_COEF  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_KERNEL_WIDTH  = 3'd2,
		REG_KERNEL_HEIGHT = 3'd3,
		REG_CHANNEL_COUNT = 3'd4
	} cfg_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// One item in flight: pixel flag, window fit, frame end, result position
	typedef struct packed {
		logic             vld;
		logic             pix;
		logic             emit;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} ctl_t;

	typedef struct packed {
		logic [IN_LANES-1:0][SUM_W-1:0] sum;
		logic [ROW_W-1:0]               row;
		logic [COL_W-1:0]               col;
		logic                           last;
	} res_t;

endpackage

[hdl/cnv_line_ram.sv]
// ----------------------------------------------------------------------------
// cnv_line_ram: one line store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cnv_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

[hdl/cnv_window.sv]
// ----------------------------------------------------------------------------
// cnv_window: line stores, window registers and coefficient store
// Builds the column for the current pixel, shifts it into the window and
// takes coefficient writes, all in the window shift stage.
// ----------------------------------------------------------------------------
module cnv_window #(
	parameter int MAX_WIDTH = 1024,
	parameter int K_MAX     = 5,
	parameter int LANES     = 3,
	parameter int CW        = $clog2(MAX_WIDTH),
	parameter int CI        = (K_MAX > 1) ? $clog2(K_MAX * K_MAX) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr_busy,
	input  logic [CW-1:0]       clr_addr,
	input  logic [CW-1:0]       rd_addr,
	input  cnv_pkg::ctl_t       ctl_s1,
	input  cnv_pkg::sample_t    smp_s1 [LANES],
	input  logic [CW-1:0]       col_s1,
	input  logic                coef_we_s1,
	input  logic [4:0]          coef_idx_s1,
	input  cnv_pkg::sample_t    coef_val_s1,
	output cnv_pkg::ctl_t       ctl_s2,
	output cnv_pkg::sample_t    win_q [K_MAX][K_MAX][LANES],
	output cnv_pkg::sample_t    coef_q [K_MAX*K_MAX]
);

	import cnv_pkg::*;

	localparam int LW = LANES * SAMPLE_W;

	logic [LW-1:0] colvec [K_MAX];
	logic [LW-1:0] rd [K_MAX];
	logic [LW-1:0] fwd_vec_q [K_MAX];
	logic          fwd_hit_q;
	logic          pix;

	assign pix = ctl_s1.vld && ctl_s1.pix;

	// Column vector: new sample on top, older rows from the line stores
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			colvec[0][l*SAMPLE_W +: SAMPLE_W] = smp_s1[l];
		end
		for (int r = 1; r < K_MAX; r++) begin
			colvec[r] = fwd_hit_q ? fwd_vec_q[r-1] : rd[r-1];
		end
	end

	assign rd[K_MAX-1] = '0;

	genvar j;
	generate
		for (j = 0; j < K_MAX - 1; j++) begin : g_line
			cnv_line_ram #(
				.DEPTH(MAX_WIDTH),
				.WIDTH(LW)
			) u_ram (
				.clk    (clk),
				.we     (clr_busy || pix),
				.waddr  (clr_busy ? clr_addr : col_s1),
				.wdata  (clr_busy ? '0 : colvec[j]),
				.raddr  (rd_addr),
				.rdata_q(rd[j])
			);
		end
	endgenerate

	// Forward the column written this cycle when the next item reads it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= pix && (col_s1 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < K_MAX; r++) begin
			fwd_vec_q[r] <= colvec[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < K_MAX; r++) begin
				for (int k = 0; k < K_MAX; k++) begin
					for (int l = 0; l < LANES; l++) begin
						win_q[r][k][l] <= '0;
					end
				end
			end
			for (int i = 0; i < K_MAX * K_MAX; i++) begin
				coef_q[i] <= '0;
			end
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			if (pix) begin
				for (int r = 0; r < K_MAX; r++) begin
					for (int l = 0; l < LANES; l++) begin
						for (int k = K_MAX - 1; k >= 1; k--) begin
							win_q[r][k][l] <= win_q[r][k-1][l];
						end
						win_q[r][0][l] <= colvec[r][l*SAMPLE_W +: SAMPLE_W];
					end
				end
			end
			if (coef_we_s1 && (32'(coef_idx_s1) < K_MAX * K_MAX)) begin
				coef_q[CI'(coef_idx_s1)] <= coef_val_s1;
			end
		end
	end

endmodule

[hdl/cnv_mac.sv]
// ----------------------------------------------------------------------------
// cnv_mac: window multiply and sum
// Registered products, registered row sums, then the window total per lane.
// ----------------------------------------------------------------------------
module cnv_mac #(
	parameter int K_MAX = 5,
	parameter int LANES = 3,
	parameter int KSW   = $clog2(K_MAX + 1),
	parameter int LW    = $clog2(LANES + 1),
	parameter int CI    = (K_MAX > 1) ? $clog2(K_MAX * K_MAX) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cnv_pkg::ctl_t    ctl_s2,
	input  cnv_pkg::sample_t win_q [K_MAX][K_MAX][LANES],
	input  cnv_pkg::sample_t coef_q [K_MAX*K_MAX],
	input  logic [KSW-1:0]   kw_eff,
	input  logic [KSW-1:0]   kh_eff,
	input  logic [LW-1:0]    ch_eff,
	output logic             res_vld,
	output cnv_pkg::res_t    res
);

	import cnv_pkg::*;

	localparam int PW  = 2 * SAMPLE_W;
	localparam int RSW = PW + $clog2(K_MAX + 1);
	localparam int TSW = PW + $clog2(K_MAX * K_MAX + 1);

	sample_t                  coef_sel [K_MAX][K_MAX];
	logic signed [PW-1:0]     prod_s3 [K_MAX][K_MAX][LANES];
	logic signed [RSW-1:0]    rsum [K_MAX][LANES];
	logic signed [RSW-1:0]    rsum_s4 [K_MAX][LANES];
	logic signed [TSW-1:0]    tot [LANES];
	ctl_t                     ctl_s3;
	ctl_t                     ctl_s4;

	// Window position (r,k) meets coefficient (kh-1-r, kw-1-k)
	always_comb begin
		for (int r = 0; r < K_MAX; r++) begin
			for (int k = 0; k < K_MAX; k++) begin
				if (r < int'(kh_eff) && k < int'(kw_eff)) begin
					coef_sel[r][k] = coef_q[CI'((int'(kh_eff) - 1 - r) * K_MAX
						+ int'(kw_eff) - 1 - k)];
				end else begin
					coef_sel[r][k] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < K_MAX; r++) begin
			for (int k = 0; k < K_MAX; k++) begin
				for (int l = 0; l < LANES; l++) begin
					prod_s3[r][k][l] <= win_q[r][k][l] * coef_sel[r][k];
				end
			end
		end
		rsum_s4 <= rsum;
	end

	always_comb begin
		for (int r = 0; r < K_MAX; r++) begin
			for (int l = 0; l < LANES; l++) begin
				rsum[r][l] = '0;
				for (int k = 0; k < K_MAX; k++) begin
					rsum[r][l] = rsum[r][l] + RSW'(prod_s3[r][k][l]);
				end
			end
		end
		for (int l = 0; l < LANES; l++) begin
			tot[l] = '0;
			for (int r = 0; r < K_MAX; r++) begin
				tot[l] = tot[l] + TSW'(rsum_s4[r][l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_comb begin
		for (int l = 0; l < IN_LANES; l++) begin
			if (l < LANES && l < int'(ch_eff)) begin
				res.sum[l] = SUM_W'(tot[(l < LANES) ? l : 0]);
			end else begin
				res.sum[l] = '0;
			end
		end
		res.row  = ctl_s4.row;
		res.col  = ctl_s4.col;
		res.last = ctl_s4.last;
	end

	assign res_vld = ctl_s4.vld && ctl_s4.pix && ctl_s4.emit;

endmodule

[hdl/valid_2d_convolution.sv]
// ----------------------------------------------------------------------------
// valid_2d_convolution: streaming 2D valid-region correlation
// Raster pixel stream in, one window sum per channel out for every position
// where the kernel fits inside the image.
// ----------------------------------------------------------------------------
// The block takes one item per clock, pixel or coefficient, while in_ready
// is high; a result passes the input register, window shift, products and
// row sums, then the output queue. Sustained rate is one item per cycle as
// long as the sink takes results; an eight-entry output queue with credit
// counting holds ready low only when the queue and the four pipeline stages
// could otherwise overflow. After reset the line stores are swept to zero,
// one column address per cycle, with in_ready low until the sweep is done;
// configuration writes are taken at all times. Write configuration only
// while the block is idle. Writing a geometry register restarts the frame;
// the channel count takes effect at once.
// ----------------------------------------------------------------------------
module valid_2d_convolution #(
	parameter int MAX_WIDTH = 1024,
	parameter int K_MAX     = 5,
	parameter int LANES     = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [4:0]                          coef_index,
	input  logic signed [cnv_pkg::SAMPLE_W-1:0] coef_value,
	input  logic signed [cnv_pkg::SAMPLE_W-1:0] sample_c0,
	input  logic signed [cnv_pkg::SAMPLE_W-1:0] sample_c1,
	input  logic signed [cnv_pkg::SAMPLE_W-1:0] sample_c2,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [cnv_pkg::SUM_W-1:0]    sum_c0,
	output logic signed [cnv_pkg::SUM_W-1:0]    sum_c1,
	output logic signed [cnv_pkg::SUM_W-1:0]    sum_c2,
	output logic [cnv_pkg::ROW_W-1:0]           out_row,
	output logic [cnv_pkg::COL_W-1:0]           out_col,
	output logic                                frame_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cnv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cnv_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import cnv_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int KSW    = $clog2(K_MAX + 1);
	localparam int LW     = $clog2(LANES + 1);
	localparam int CH_MAX = (LANES < IN_LANES) ? LANES : IN_LANES;
	localparam int FD     = 8;
	localparam int FPW    = $clog2(FD);
	localparam int FCW    = $clog2(FD + 1);

	// configuration registers
	logic [10:0] img_w_q;
	logic [12:0] img_h_q;
	logic [2:0]  ker_w_q;
	logic [2:0]  ker_h_q;
	logic [1:0]  chan_q;

	// effective (clamped) geometry
	logic [WW-1:0]  w_eff;
	logic [12:0]    h_eff;
	logic [KSW-1:0] kw_eff;
	logic [KSW-1:0] kh_eff;
	logic [LW-1:0]  ch_eff;

	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_cur;
	logic [CW-1:0]    col_cur;
	logic             emit_cur;
	logic             last_cur;
	logic             wrap_col;
	logic             wrap_row;

	logic          clr_busy_q;
	logic [CW-1:0] clr_addr_q;

	logic in_xfer;
	logic pix_xfer;
	logic geo_wr;

	ctl_t          ctl_s1;
	ctl_t          ctl_s2;
	sample_t       smp_s1 [LANES];
	logic [CW-1:0] col_s1;
	logic [4:0]    coef_idx_s1;
	sample_t       coef_val_s1;
	logic          coef_we_s1;

	sample_t win_q [K_MAX][K_MAX][LANES];
	sample_t coef_q [K_MAX*K_MAX];

	logic res_vld;
	res_t res;

	res_t           fifo_q [FD];
	logic [FPW-1:0] wr_ptr_q;
	logic [FPW-1:0] rd_ptr_q;
	logic [FCW-1:0] cnt_q;
	logic [FCW-1:0] infl_q;
	logic           pop;
	logic           credit;

	// Clamp registers: zero reads as one, large values saturate
	always_comb begin
		if (img_w_q == '0)                 w_eff = WW'(1);
		else if (32'(img_w_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else                               w_eff = WW'(img_w_q);
		if (img_h_q == '0)                  h_eff = 13'd1;
		else if (32'(img_h_q) > MAX_HEIGHT) h_eff = 13'(MAX_HEIGHT);
		else                                h_eff = img_h_q;
		if (ker_w_q == '0)             kw_eff = KSW'(1);
		else if (32'(ker_w_q) > K_MAX) kw_eff = KSW'(K_MAX);
		else                           kw_eff = KSW'(ker_w_q);
		if (ker_h_q == '0)             kh_eff = KSW'(1);
		else if (32'(ker_h_q) > K_MAX) kh_eff = KSW'(K_MAX);
		else                           kh_eff = KSW'(ker_h_q);
		if (chan_q == '0)             ch_eff = LW'(1);
		else if (32'(chan_q) > CH_MAX) ch_eff = LW'(CH_MAX);
		else                          ch_eff = LW'(chan_q);
	end

	// Position of the incoming pixel, held inside the frame
	always_comb begin
		col_cur  = (32'(col_q) >= 32'(w_eff)) ? CW'(32'(w_eff) - 1) : col_q;
		row_cur  = (32'(row_q) >= 32'(h_eff)) ? ROW_W'(32'(h_eff) - 1) : row_q;
		emit_cur = (32'(row_cur) + 1 >= 32'(kh_eff)) && (32'(col_cur) + 1 >= 32'(kw_eff));
		last_cur = (32'(row_cur) == 32'(h_eff) - 1) && (32'(col_cur) == 32'(w_eff) - 1);
		wrap_col = (32'(col_cur) + 1 >= 32'(w_eff));
		wrap_row = (32'(row_cur) + 1 >= 32'(h_eff));
	end

	assign credit    = (32'(cnt_q) + 32'(infl_q)) < FD;
	assign in_ready  = !clr_busy_q && credit;
	assign in_xfer   = in_valid && in_ready;
	assign pix_xfer  = in_xfer && (req_type == REQ_PIXEL);
	assign cfg_ready = 1'b1;
	assign geo_wr    = cfg_valid && (cfg_index == REG_IMAGE_WIDTH ||
		cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_KERNEL_WIDTH ||
		cfg_index == REG_KERNEL_HEIGHT);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= 11'd1024;
			img_h_q <= 13'd1;
			ker_w_q <= 3'd3;
			ker_h_q <= 3'd3;
			chan_q  <= 2'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   img_w_q <= cfg_data[10:0];
				REG_IMAGE_HEIGHT:  img_h_q <= cfg_data[12:0];
				REG_KERNEL_WIDTH:  ker_w_q <= cfg_data[2:0];
				REG_KERNEL_HEIGHT: ker_h_q <= cfg_data[2:0];
				REG_CHANNEL_COUNT: chan_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Raster counters: advance on each pixel, restart on a geometry write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (geo_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (pix_xfer) begin
			if (wrap_col) begin
				col_q <= '0;
				row_q <= wrap_row ? '0 : ROW_W'(32'(row_cur) + 1);
			end else begin
				col_q <= CW'(32'(col_cur) + 1);
			end
		end
	end

	// Sweep the line stores to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= CW'(32'(clr_addr_q) + 1);
			if (32'(clr_addr_q) == MAX_WIDTH - 1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Input register (stage one)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1     <= '0;
			coef_we_s1 <= 1'b0;
		end else begin
			ctl_s1.vld  <= in_xfer;
			ctl_s1.pix  <= pix_xfer;
			ctl_s1.emit <= emit_cur;
			ctl_s1.last <= last_cur;
			ctl_s1.row  <= ROW_W'(32'(row_cur) + 1 - 32'(kh_eff));
			ctl_s1.col  <= COL_W'(32'(col_cur) + 1 - 32'(kw_eff));
			coef_we_s1  <= in_xfer && (req_type == REQ_COEF);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (l == 0)      smp_s1[l] <= sample_c0;
			else if (l == 1) smp_s1[l] <= sample_c1;
			else if (l == 2) smp_s1[l] <= sample_c2;
			else             smp_s1[l] <= '0;
		end
		col_s1      <= col_cur;
		coef_idx_s1 <= coef_index;
		coef_val_s1 <= coef_value;
	end

	cnv_window #(
		.MAX_WIDTH(MAX_WIDTH),
		.K_MAX    (K_MAX),
		.LANES    (LANES)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr_busy   (clr_busy_q),
		.clr_addr   (clr_addr_q),
		.rd_addr    (col_cur),
		.ctl_s1     (ctl_s1),
		.smp_s1     (smp_s1),
		.col_s1     (col_s1),
		.coef_we_s1 (coef_we_s1),
		.coef_idx_s1(coef_idx_s1),
		.coef_val_s1(coef_val_s1),
		.ctl_s2     (ctl_s2),
		.win_q      (win_q),
		.coef_q     (coef_q)
	);

	cnv_mac #(
		.K_MAX(K_MAX),
		.LANES(LANES)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s2 (ctl_s2),
		.win_q  (win_q),
		.coef_q (coef_q),
		.kw_eff (kw_eff),
		.kh_eff (kh_eff),
		.ch_eff (ch_eff),
		.res_vld(res_vld),
		.res    (res)
	);

	// Output queue; infl_q counts results still in the pipeline
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (res_vld) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			infl_q   <= '0;
		end else begin
			if (res_vld) wr_ptr_q <= FPW'(32'(wr_ptr_q) + 1);
			if (pop)     rd_ptr_q <= FPW'(32'(rd_ptr_q) + 1);
			cnt_q  <= FCW'(32'(cnt_q) + 32'(res_vld) - 32'(pop));
			infl_q <= FCW'(32'(infl_q) + 32'(pix_xfer && emit_cur) - 32'(res_vld));
		end
	end

	assign out_valid  = (cnt_q != '0);
	assign sum_c0     = fifo_q[rd_ptr_q].sum[0];
	assign sum_c1     = fifo_q[rd_ptr_q].sum[1];
	assign sum_c2     = fifo_q[rd_ptr_q].sum[2];
	assign out_row    = fifo_q[rd_ptr_q].row;
	assign out_col    = fifo_q[rd_ptr_q].col;
	assign frame_last = fifo_q[rd_ptr_q].last;

	// Credit accounting never promises more than the queue holds
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cnt_q) + 32'(infl_q)) <= FD)
		else $error("output queue credit overrun");

	// A result never lands in a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> (32'(cnt_q) < FD))
		else $error("result pushed into full queue");

	// No item enters while the line stores are being cleared
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("input accepted during line store clear");

	// Every result arrives with a credit that was taken for it
	a_infl: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> (infl_q != '0))
		else $error("result without a pending credit");

endmodule
